// ----- hw/rtl/sdspi_pkg.sv -----
package sdspi_pkg;

	localparam logic [1:0] OP_CMD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_SLOT  = 2'd3;

	localparam logic [1:0] RESP_R1  = 2'd0;
	localparam logic [1:0] RESP_R1B = 2'd1;
	localparam logic [1:0] RESP_R2  = 2'd2;
	localparam logic [1:0] RESP_R3  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_R1_ERR  = 2'd2;

	localparam logic [1:0] CMD_START_BITS = 2'b01;
	localparam logic [7:0] BYTE_IDLE      = 8'hFF;
	localparam logic [7:0] TOKEN_START    = 8'hFE;
	localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
	localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;

	localparam logic [7:0] RESP_TIMEOUT = 8'd255;
	localparam logic [7:0] TOKEN_WAIT   = 8'd100;
	localparam int BLOCK_SHIFT          = 9;
	localparam logic [9:0] BLOCK_BYTES  = 10'd512;
	localparam logic [9:0] FRAME_BYTES  = 10'd6;
	localparam logic [9:0] CRC_BYTES    = 10'd2;

	typedef enum logic [13:0] {
		PH_IDLE     = 14'h0001,
		PH_SEND     = 14'h0002,
		PH_POLL     = 14'h0004,
		PH_COLLECT  = 14'h0008,
		PH_BUSY     = 14'h0010,
		PH_BUSYEND  = 14'h0020,
		PH_TOKEN    = 14'h0040,
		PH_RD_DATA  = 14'h0080,
		PH_RD_CRC   = 14'h0100,
		PH_FILL     = 14'h0200,
		PH_WR_TOKEN = 14'h0400,
		PH_WR_DATA  = 14'h0800,
		PH_WR_CRC   = 14'h1000,
		PH_WR_BUSY  = 14'h2000
	} phase_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		logic [7:0]  cmd_crc;
		logic [1:0]  resp_kind;
		logic [7:0]  rx_byte;
		logic [7:0]  wr_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_valid;
		logic        chip_select_n;
		logic [7:0]  rd_byte;
		logic        rd_valid;
		logic        wr_request;
		logic        done_res;
		logic [1:0]  status;
		logic [39:0] response;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  op_kind;
		logic [47:0] frame_shift;
		logic [9:0]  byte_count;
		logic [7:0]  wait_count;
		logic [1:0]  resp_type;
		logic [39:0] resp_shift;
	} state_t;

endpackage

// ----- hw/rtl/sdspi_if.sv -----
interface sdspi_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [5:0]  cmd_index;
	logic [31:0] cmd_argument;
	logic [7:0]  cmd_crc;
	logic [1:0]  resp_kind;
	logic [7:0]  rx_byte;
	logic [7:0]  wr_byte;

	modport source (output valid, operation, cmd_index, cmd_argument, cmd_crc, resp_kind,
		rx_byte, wr_byte, input ready);
	modport sink (input valid, operation, cmd_index, cmd_argument, cmd_crc, resp_kind,
		rx_byte, wr_byte, output ready);
endinterface

interface sdspi_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  tx_byte;
	logic        tx_valid;
	logic        chip_select_n;
	logic [7:0]  rd_byte;
	logic        rd_valid;
	logic        wr_request;
	logic        done_res;
	logic [1:0]  status;
	logic [39:0] response;

	modport source (output valid, tx_byte, tx_valid, chip_select_n, rd_byte, rd_valid,
		wr_request, done_res, status, response, input ready);
	modport sink (input valid, tx_byte, tx_valid, chip_select_n, rd_byte, rd_valid,
		wr_request, done_res, status, response, output ready);
endinterface

// ----- hw/rtl/sdspi_step.sv -----
module sdspi_step import sdspi_pkg::*; #(
	parameter logic [7:0] POLL_LIMIT  = RESP_TIMEOUT,
	parameter logic [7:0] TOKEN_LIMIT = TOKEN_WAIT
) (
	input  state_t  st,
	input  item_t   item,
	output state_t  nx,
	output result_t res
);

	logic [5:0]  idx;
	logic [31:0] arg;
	logic [7:0]  crc;
	logic [47:0] frame;
	logic [7:0]  wc_inc;
	logic [9:0]  bc_inc;
	logic        over;

	function automatic result_t slot_res(input logic [7:0] b);
		result_t r;
		r = '0;
		r.tx_byte = b;
		r.tx_valid = 1'b1;
		r.chip_select_n = 1'b0;
		return r;
	endfunction

	function automatic result_t finish_res(input logic [1:0] s, input logic [39:0] rsp);
		result_t r;
		r = '0;
		r.chip_select_n = 1'b1;
		r.done_res = 1'b1;
		r.status = s;
		r.response = rsp;
		return r;
	endfunction

	assign wc_inc = st.wait_count + 8'd1;
	assign bc_inc = st.byte_count + 10'd1;

	always_comb begin
		nx = st;
		res = '0;
		res.chip_select_n = (st.phase == PH_IDLE);
		idx = item.cmd_index;
		arg = item.cmd_argument;
		crc = item.cmd_crc;
		frame = '0;
		over = 1'b0;
		if (item.operation != OP_SLOT) begin
			if (st.phase == PH_IDLE) begin
				if (item.operation == OP_CMD) begin
					nx.resp_type = item.resp_kind;
				end else begin
					idx = (item.operation == OP_READ) ? CMD_READ_BLOCK : CMD_WRITE_BLOCK;
					arg = {item.cmd_argument[31-BLOCK_SHIFT:0], {BLOCK_SHIFT{1'b0}}};
					crc = BYTE_IDLE;
					nx.resp_type = RESP_R1;
				end
				frame = {CMD_START_BITS, idx, arg, crc};
				nx.op_kind = item.operation;
				nx.frame_shift = {frame[39:0], 8'h00};
				nx.byte_count = 10'd1;
				nx.wait_count = '0;
				nx.resp_shift = '0;
				nx.phase = PH_SEND;
				res = slot_res(frame[47:40]);
			end
		end else begin
			unique case (st.phase)
				PH_IDLE: begin
					res.chip_select_n = 1'b1;
				end
				PH_SEND: begin
					if (st.byte_count < FRAME_BYTES) begin
						res = slot_res(st.frame_shift[47:40]);
						nx.frame_shift = {st.frame_shift[39:0], 8'h00};
						nx.byte_count = bc_inc;
					end else begin
						nx.phase = PH_POLL;
						nx.wait_count = '0;
						res = slot_res(BYTE_IDLE);
					end
				end
				PH_POLL: begin
					nx.wait_count = wc_inc;
					if (!item.rx_byte[7]) begin
						nx.resp_shift = {32'd0, item.rx_byte};
						unique case (st.resp_type)
							RESP_R2: nx.byte_count = 10'd1;
							RESP_R3: nx.byte_count = 10'd4;
							default: nx.byte_count = 10'd0;
						endcase
						nx.phase = PH_COLLECT;
						res = slot_res(BYTE_IDLE);
					end else if (wc_inc >= POLL_LIMIT) begin
						nx.resp_shift = '0;
						nx.phase = PH_IDLE;
						res = finish_res(ST_TIMEOUT, '0);
					end else begin
						res = slot_res(BYTE_IDLE);
					end
				end
				PH_COLLECT: begin
					if (st.byte_count != 10'd0) begin
						nx.resp_shift = {st.resp_shift[31:0], item.rx_byte};
						nx.byte_count = st.byte_count - 10'd1;
						res = slot_res(BYTE_IDLE);
					end else if (st.resp_type == RESP_R1B) begin
						nx.phase = PH_BUSY;
						res = slot_res(BYTE_IDLE);
					end else begin
						over = 1'b1;
					end
				end
				PH_BUSY: begin
					if (item.rx_byte == BYTE_IDLE) begin
						nx.phase = PH_BUSYEND;
					end
					res = slot_res(BYTE_IDLE);
				end
				PH_BUSYEND: begin
					over = 1'b1;
				end
				PH_TOKEN: begin
					nx.wait_count = wc_inc;
					if (item.rx_byte == TOKEN_START || wc_inc >= TOKEN_LIMIT) begin
						nx.phase = PH_RD_DATA;
						nx.byte_count = '0;
					end
					res = slot_res(BYTE_IDLE);
				end
				PH_RD_DATA: begin
					res = slot_res(BYTE_IDLE);
					res.rd_byte = item.rx_byte;
					res.rd_valid = 1'b1;
					nx.byte_count = bc_inc;
					if (bc_inc >= BLOCK_BYTES) begin
						nx.phase = PH_RD_CRC;
						nx.byte_count = '0;
					end
				end
				PH_RD_CRC: begin
					nx.byte_count = bc_inc;
					if (bc_inc >= CRC_BYTES) begin
						nx.phase = PH_IDLE;
						res = finish_res(ST_OK, st.resp_shift);
					end else begin
						res = slot_res(BYTE_IDLE);
					end
				end
				PH_FILL: begin
					nx.phase = PH_WR_TOKEN;
					res = slot_res(TOKEN_START);
					res.wr_request = 1'b1;
				end
				PH_WR_TOKEN: begin
					nx.phase = PH_WR_DATA;
					nx.byte_count = 10'd1;
					res = slot_res(item.wr_byte);
					res.wr_request = (10'd1 < BLOCK_BYTES);
				end
				PH_WR_DATA: begin
					if (st.byte_count < BLOCK_BYTES) begin
						nx.byte_count = bc_inc;
						res = slot_res(item.wr_byte);
						res.wr_request = (bc_inc < BLOCK_BYTES);
					end else begin
						nx.phase = PH_WR_CRC;
						nx.byte_count = 10'd1;
						res = slot_res(BYTE_IDLE);
					end
				end
				PH_WR_CRC: begin
					if (st.byte_count < CRC_BYTES) begin
						nx.byte_count = CRC_BYTES;
					end else begin
						nx.phase = PH_WR_BUSY;
					end
					res = slot_res(BYTE_IDLE);
				end
				PH_WR_BUSY: begin
					if (item.rx_byte == BYTE_IDLE) begin
						nx.phase = PH_IDLE;
						res = finish_res(ST_OK, st.resp_shift);
					end else begin
						res = slot_res(BYTE_IDLE);
					end
				end
				default: begin
					nx.phase = PH_IDLE;
					res.chip_select_n = 1'b1;
				end
			endcase
			if (over) begin
				if (st.op_kind == OP_CMD) begin
					nx.phase = PH_IDLE;
					res = finish_res(ST_OK, st.resp_shift);
				end else if (st.resp_shift[7:0] != 8'd0) begin
					nx.phase = PH_IDLE;
					res = finish_res(ST_R1_ERR, st.resp_shift);
				end else if (st.op_kind == OP_READ) begin
					nx.phase = PH_TOKEN;
					nx.wait_count = '0;
					res = slot_res(BYTE_IDLE);
				end else begin
					nx.phase = PH_FILL;
					res = slot_res(BYTE_IDLE);
				end
			end
		end
	end

endmodule

// ----- hw/rtl/sd_spi_command_block_engine.sv -----
// SD card SPI-mode command and block engine, master side.
// req carries one item per SPI byte slot: a request (command, block read,
// block write) opens a transaction, and each later item reports a completed
// slot with the byte the card returned and, when asked for, a write byte.
// res returns exactly one item per req item: the byte for the next slot,
// chip select level, read data, write data request, and on the last item of
// a transaction the status and gathered response.
// The result is registered: a req item passes the input register, then the
// sequencer step into the result register, where res can take it.
// Throughput is one item per cycle while res takes its items; the state
// update is registered together with the result, so the next item sees the
// new state straight away.
// When res stalls, the held result and the input register keep their
// items, and req.ready stays low while both are full until res takes its item.
// POLL_LIMIT bounds the response poll and TOKEN_LIMIT the read token wait.
// Reset clears the sequencer to idle with chip select released and drops
// any item in flight.
module sd_spi_command_block_engine import sdspi_pkg::*; #(
	parameter logic [7:0] POLL_LIMIT  = RESP_TIMEOUT,
	parameter logic [7:0] TOKEN_LIMIT = TOKEN_WAIT
) (
	input  logic        clk,
	input  logic        arst_n,
	sdspi_req_if.sink   req,
	sdspi_res_if.source res
);

	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nx;
	result_t res_nx;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	item_t   req_item;

	assign advance = !valid_s2 || res.ready;
	assign req.ready = !valid_s1 || advance;

	assign req_item = '{operation: req.operation, cmd_index: req.cmd_index,
		cmd_argument: req.cmd_argument, cmd_crc: req.cmd_crc, resp_kind: req.resp_kind,
		rx_byte: req.rx_byte, wr_byte: req.wr_byte};

	sdspi_step #(
		.POLL_LIMIT  (POLL_LIMIT),
		.TOKEN_LIMIT (TOKEN_LIMIT)
	) u_step (
		.st   (state_q),
		.item (item_s1),
		.nx   (state_nx),
		.res  (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= '{phase: PH_IDLE, default: '0};
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req_item;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_nx;
		end
	end

	assign res.valid = valid_s2;
	assign res.tx_byte = res_s2.tx_byte;
	assign res.tx_valid = res_s2.tx_valid;
	assign res.chip_select_n = res_s2.chip_select_n;
	assign res.rd_byte = res_s2.rd_byte;
	assign res.rd_valid = res_s2.rd_valid;
	assign res.wr_request = res_s2.wr_request;
	assign res.done_res = res_s2.done_res;
	assign res.status = res_s2.status;
	assign res.response = res_s2.response;

endmodule
